>>> hdl/fbpt_pkg.sv
// Package for the frame buffer push transition block.
// Holds opcode and direction codes, item types and the controller/datapath command types.
package fbpt_pkg;

    typedef enum logic [1:0] {
        KIND_WR_SHOWN = 2'd0,
        KIND_WR_INCOMING = 2'd1,
        KIND_RD_SHOWN = 2'd2,
        KIND_STEP = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        DIR_UP2 = 3'd0,
        DIR_DOWN2 = 3'd1,
        DIR_LEFT2 = 3'd2,
        DIR_RIGHT2 = 3'd3,
        DIR_DOWN1 = 3'd4
    } dir_t;

    // input item and result item carried on the channels
    typedef struct packed {
        kind_t kind;
        logic [9:0] address;
        logic [7:0] data;
        logic [2:0] direction;
        logic [5:0] step;
    } req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic frame_ready;
    } rsp_t;

    // datapath command phases issued by the controller
    typedef enum logic [2:0] {
        CMD_NONE = 3'd0,
        CMD_HOST_WR_SHOWN = 3'd1,
        CMD_HOST_WR_INC = 3'd2,
        CMD_HOST_RD = 3'd3,
        CMD_SWEEP = 3'd4,
        CMD_CLEAR = 3'd5
    } cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic start;
    } ctrl_t;

    typedef struct packed {
        logic done;
    } stat_t;

endpackage

>>> hdl/fbpt_if.sv
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing; the payload type is a parameter.
interface fbpt_if #(
    parameter type payload_t = logic
);
    logic valid;
    logic ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> hdl/fbpt_datapath.sv
// Datapath: shown frame and incoming image memories plus the sweep engine.
// Depends on fbpt_pkg; commanded by fbpt_ctrl.
module fbpt_datapath #(
    parameter int COLUMNS = 128,
    parameter int PAGES = 8,
    localparam int CW = $clog2(COLUMNS),
    localparam int PW = $clog2(PAGES),
    localparam int AW = CW + PW,
    localparam int DEPTH = COLUMNS * PAGES
) (
    input logic clk,
    input logic rst_n,
    input fbpt_pkg::ctrl_t ctrl,
    output fbpt_pkg::stat_t stat,
    input logic [9:0] address,
    input logic [7:0] data,
    input logic [2:0] direction,
    input logic [5:0] step,
    output logic [7:0] read_data
);

    logic [7:0] shown_mem [DEPTH];
    logic [7:0] inc_mem [DEPTH];

    // sweep walks every byte once: a read phase, then a write phase
    // Order: for up2/left2 ascending, for down/right descending, so a source
    // byte is always read before its own update.
    logic [AW:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic phase_reg, phase_next;
    logic clear_reg, clear_next;
    logic [2:0] dir_reg;
    logic [5:0] step_reg;
    logic rd_sel_reg;
    logic [7:0] sh_q, sh_nb_q, inc_q;
    logic [AW-1:0] addr_cur;
    logic [AW-1:0] host_addr;
    logic descend;
    logic done_reg;

    logic in_frame;
    assign in_frame = 32'(address) < 32'(DEPTH);
    assign host_addr = AW'(address);

    assign descend = (dir_reg == fbpt_pkg::DIR_DOWN2) || (dir_reg == fbpt_pkg::DIR_RIGHT2)
        || (dir_reg == fbpt_pkg::DIR_DOWN1);
    assign addr_cur = descend ? AW'(DEPTH - 1 - int'(cnt_reg)) : cnt_reg[AW-1:0];

    logic [CW-1:0] col;
    logic [PW-1:0] pg;
    assign col = addr_cur[CW-1:0];
    assign pg = addr_cur[AW-1:CW];

    // neighbor read address and incoming source address
    logic [AW-1:0] nb_addr, src_addr;
    logic [5:0] s32;
    logic [5:0] s64;
    logic [CW-2:0] sc;
    assign s32 = step_reg & 6'((4 * PAGES) - 1 > 63 ? 63 : (4 * PAGES) - 1);
    assign s64 = step_reg & 6'((8 * PAGES) - 1 > 63 ? 63 : (8 * PAGES) - 1);
    assign sc = (CW - 1)'(step_reg);

    always_comb
    begin
        nb_addr = addr_cur;
        src_addr = addr_cur;
        unique case (dir_reg)
            fbpt_pkg::DIR_UP2:
            begin
                nb_addr = addr_cur + AW'(COLUMNS);
                src_addr = {PW'(s32 >> 2), col};
            end
            fbpt_pkg::DIR_DOWN2:
            begin
                nb_addr = addr_cur - AW'(COLUMNS);
                src_addr = {PW'(PAGES - 1) - PW'(s32 >> 2), col};
            end
            fbpt_pkg::DIR_DOWN1:
            begin
                nb_addr = addr_cur - AW'(COLUMNS);
                src_addr = {PW'(PAGES - 1) - PW'(s64 >> 3), col};
            end
            fbpt_pkg::DIR_LEFT2:
            begin
                nb_addr = addr_cur + AW'(2);
                src_addr = {pg, CW'({sc, 1'b0}) + CW'(col - CW'(COLUMNS - 2))};
            end
            fbpt_pkg::DIR_RIGHT2:
            begin
                nb_addr = addr_cur - AW'(2);
                src_addr = {pg, CW'(COLUMNS - 2) - CW'({sc, 1'b0}) + col};
            end
            default:
            begin
                nb_addr = addr_cur;
            end
        endcase
    end

    // new byte from registered reads
    logic [7:0] new_byte;
    logic [2:0] sh2;
    logic [2:0] sh1;
    logic last_page, first_page, edge_col;
    logic [AW-1:0] wr_addr_reg;
    logic [2:0] wdir;
    logic wlast, wfirst, wedge;
    logic [CW-1:0] wcol;
    logic [5:0] ws32;
    logic [5:0] ws64;
    assign last_page = pg == PW'(PAGES - 1);
    assign first_page = pg == '0;
    assign edge_col = (dir_reg == fbpt_pkg::DIR_LEFT2) ? (col >= CW'(COLUMNS - 2))
        : (col < CW'(2));
    logic wlast_reg, wfirst_reg, wedge_reg;
    assign wlast = wlast_reg;
    assign wfirst = wfirst_reg;
    assign wedge = wedge_reg;
    assign wdir = dir_reg;
    assign wcol = wr_addr_reg[CW-1:0];
    assign ws32 = s32;
    assign ws64 = s64;
    assign sh2 = 3'(6 - 2 * int'(ws32[1:0]));
    assign sh1 = 3'(7 - int'(ws64[2:0]));

    always_comb
    begin
        new_byte = sh_q;
        unique case (wdir)
            fbpt_pkg::DIR_UP2:
                new_byte = wlast ? ((sh_q >> 2) | ((inc_q << sh2) & 8'hc0))
                    : ((sh_nb_q << 6) | (sh_q >> 2));
            fbpt_pkg::DIR_DOWN2:
                new_byte = wfirst ? ((sh_q << 2) | ((inc_q >> sh2) & 8'h03))
                    : ((sh_q << 2) | (sh_nb_q >> 6));
            fbpt_pkg::DIR_DOWN1:
                new_byte = wfirst ? ((sh_q << 1) | ((inc_q >> sh1) & 8'h01))
                    : ((sh_q << 1) | (sh_nb_q >> 7));
            fbpt_pkg::DIR_LEFT2, fbpt_pkg::DIR_RIGHT2:
                new_byte = wedge ? inc_q : sh_nb_q;
            default:
                new_byte = sh_q;
        endcase
    end

    // neighbor data: the neighbor was not yet rewritten in sweep order, so
    // reading memory gives its old value
    always_ff @(posedge clk)
    begin
        if (ctrl.cmd == fbpt_pkg::CMD_HOST_WR_SHOWN && in_frame)
            shown_mem[host_addr] <= data;
        else if (clear_reg)
            shown_mem[cnt_reg[AW-1:0]] <= 8'h00;
        else if (busy_reg && phase_reg)
            shown_mem[wr_addr_reg] <= new_byte;
        if (ctrl.cmd == fbpt_pkg::CMD_HOST_WR_INC && in_frame)
            inc_mem[host_addr] <= data;
        // one port serves host reads and the sweep; hold the byte between items
        if (ctrl.cmd == fbpt_pkg::CMD_HOST_RD)
            sh_q <= shown_mem[host_addr];
        else if (busy_reg)
            sh_q <= shown_mem[addr_cur];
        sh_nb_q <= shown_mem[nb_addr];
        inc_q <= inc_mem[src_addr];
        wr_addr_reg <= addr_cur;
        wlast_reg <= last_page;
        wfirst_reg <= first_page;
        wedge_reg <= edge_col;
        if (ctrl.start)
        begin
            dir_reg <= direction;
            step_reg <= step;
        end
    end
    assign read_data = rd_sel_reg ? sh_q : 8'h00;

    always_comb
    begin
        busy_next = busy_reg;
        phase_next = phase_reg;
        cnt_next = cnt_reg;
        clear_next = clear_reg;
        if (clear_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == (AW+1)'(DEPTH - 1))
            begin
                clear_next = 1'b0;
                cnt_next = '0;
            end
        end
        else if (ctrl.start)
        begin
            busy_next = 1'b1;
            phase_next = 1'b0;
            cnt_next = '0;
        end
        else if (busy_reg)
        begin
            phase_next = !phase_reg;
            if (phase_reg)
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == (AW+1)'(DEPTH - 1))
                begin
                    busy_next = 1'b0;
                    cnt_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            phase_reg <= 1'b0;
            cnt_reg <= '0;
            clear_reg <= 1'b1;
            rd_sel_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            phase_reg <= phase_next;
            cnt_reg <= cnt_next;
            clear_reg <= clear_next;
            // only an in-frame read answers with memory data
            if (ctrl.cmd != fbpt_pkg::CMD_NONE)
                rd_sel_reg <= (ctrl.cmd == fbpt_pkg::CMD_HOST_RD) && in_frame;
            done_reg <= (busy_reg && !busy_next) || (clear_reg && !clear_next);
        end
    end

    assign stat.done = done_reg;

endmodule

>>> hdl/fbpt_ctrl.sv
// Controller: accepts items, sequences datapath commands, holds the result.
// Depends on fbpt_pkg.
module fbpt_ctrl (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    output logic in_ready,
    input logic [1:0] kind,
    input logic [2:0] direction,
    output fbpt_pkg::ctrl_t ctrl,
    input fbpt_pkg::stat_t stat,
    output logic out_valid,
    input logic out_ready,
    output logic frame_ready
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_SWEEP,
        S_DONE
    } state_t;

    state_t state_reg;
    logic out_valid_reg;
    logic frame_ready_reg;
    logic accept;
    logic valid_dir;

    // a new item waits while the previous result is still held
    assign in_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign accept = in_valid && in_ready;
    assign valid_dir = direction <= 3'(fbpt_pkg::DIR_DOWN1);

    always_comb
    begin
        ctrl.cmd = fbpt_pkg::CMD_NONE;
        ctrl.start = 1'b0;
        if (accept)
        begin
            unique case (kind)
                fbpt_pkg::KIND_WR_SHOWN: ctrl.cmd = fbpt_pkg::CMD_HOST_WR_SHOWN;
                fbpt_pkg::KIND_WR_INCOMING: ctrl.cmd = fbpt_pkg::CMD_HOST_WR_INC;
                fbpt_pkg::KIND_RD_SHOWN: ctrl.cmd = fbpt_pkg::CMD_HOST_RD;
                default:
                begin
                    ctrl.cmd = fbpt_pkg::CMD_SWEEP;
                    ctrl.start = valid_dir;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            out_valid_reg <= 1'b0;
            frame_ready_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                    if (stat.done)
                        state_reg <= S_IDLE;
                S_IDLE:
                    if (accept)
                    begin
                        if (kind == fbpt_pkg::KIND_STEP && valid_dir)
                            state_reg <= S_SWEEP;
                        else if (kind == fbpt_pkg::KIND_RD_SHOWN)
                            state_reg <= S_READ;
                        else
                        begin
                            out_valid_reg <= 1'b1;
                            frame_ready_reg <= 1'b0;
                        end
                    end
                S_READ:
                begin
                    out_valid_reg <= 1'b1;
                    frame_ready_reg <= 1'b0;
                    state_reg <= S_IDLE;
                end
                S_SWEEP:
                    if (stat.done)
                        state_reg <= S_DONE;
                S_DONE:
                begin
                    out_valid_reg <= 1'b1;
                    frame_ready_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign frame_ready = frame_ready_reg;

endmodule

>>> hdl/framebuffer_push_transition_top.sv
// Top level of the frame buffer push transition engine.
// Depends on fbpt_pkg, fbpt_if, fbpt_ctrl and fbpt_datapath.
//
// A write of a single byte is answered straight from S_IDLE, a read through
// S_READ. A step rewrites every byte of the shown frame through the
// shown-frame memory, one read and one write per byte, so its result is
// offered after the sweep ends and S_DONE, and the next item is taken only
// once that result has been transferred. After reset a clearing pass
// zeroes the shown frame before the first item is taken. Every item
// answers with one result transfer.
module framebuffer_push_transition_top #(
    parameter int COLUMNS = 128,
    parameter int PAGES = 8
) (
    input logic clk,
    input logic rst_n,
    fbpt_if.sink in_ch,
    fbpt_if.source out_ch
);

    fbpt_pkg::ctrl_t ctrl;
    fbpt_pkg::stat_t stat;
    logic [7:0] rd;
    logic fr;

    fbpt_ctrl u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_ch.valid),
        .in_ready(in_ch.ready),
        .kind(in_ch.payload.kind),
        .direction(in_ch.payload.direction),
        .ctrl(ctrl),
        .stat(stat),
        .out_valid(out_ch.valid),
        .out_ready(out_ch.ready),
        .frame_ready(fr)
    );

    fbpt_datapath #(
        .COLUMNS(COLUMNS),
        .PAGES(PAGES)
    ) u_dp (
        .clk(clk),
        .rst_n(rst_n),
        .ctrl(ctrl),
        .stat(stat),
        .address(in_ch.payload.address),
        .data(in_ch.payload.data),
        .direction(in_ch.payload.direction),
        .step(in_ch.payload.step),
        .read_data(rd)
    );

    // read data is held by the memory read register until the next item
    assign out_ch.payload.read_data = fr ? 8'h00 : rd;
    assign out_ch.payload.frame_ready = fr;

    a_no_accept_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !in_ch.ready)
        else $error("item accepted while a result is pending");

    a_sweep_start: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |=> !in_ch.ready)
        else $error("input ready during a sweep");

endmodule
